/* rtl/xor_checked_frame_deframer_assert.svh */
// Assertion macros used by the checker file of the deframer.
// Depends on nothing; the user must provide clk and arst_n in scope.
`ifndef XOR_CHECKED_FRAME_DEFRAMER_ASSERT_SVH
`define XOR_CHECKED_FRAME_DEFRAMER_ASSERT_SVH

// Assertion checked only while reset is released.
`define XCFD_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Assertion checked at every edge, reset included.
`define XCFD_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/xcfd_pkg.sv */
// Package for the XOR-checked frame deframer: types and constants.
// Depends on nothing.
`default_nettype none

package xcfd_pkg;

	localparam logic [7:0] START_BYTE = 8'hFF;
	localparam logic [7:0] XOR_INIT   = 8'h00;
	localparam int         TDATA_W    = 40;

	localparam logic KIND_PAYLOAD = 1'b0;
	localparam logic KIND_SUMMARY = 1'b1;

	typedef enum logic [4:0] {
		ST_HUNT  = 5'b00001,
		ST_CMD   = 5'b00010,
		ST_LEN   = 5'b00100,
		ST_DATA  = 5'b01000,
		ST_CHECK = 5'b10000
	} state_t;

	typedef struct packed {
		logic       status_error;
		logic       command_match;
		logic       checksum_ok;
		logic [7:0] frame_len;
		logic [7:0] frame_command;
		logic [7:0] byte_index;
		logic [7:0] data_byte;
	} result_t;

endpackage

`default_nettype wire

/* rtl/xor_checked_frame_deframer.sv */
// Top level of the XOR-checked frame deframer.
// Depends on xcfd_pkg.
`default_nettype none

// Takes one received byte per transfer, hunts for the start byte 0xFF, then
// parses command, length, payload and checksum. Each payload byte leaves as a
// provisional item (tuser 0); the checksum byte yields one summary (tuser 1).
// A byte is taken every cycle as long as results are taken. A taken byte passes the
// input register; state update and result register load once the output register is
// free. Output backpressure is the only stall source. The user must see that the
// match command code is written through the cfg channel only while the block is
// idle; the block itself does not enforce it.
module xor_checked_frame_deframer (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         s_axis_tvalid,
	output logic                              s_axis_tready,
	input  wire logic [7:0]                   s_axis_tdata,  // rx_byte
	output logic                              m_axis_tvalid,
	input  wire logic                         m_axis_tready,
	// data_byte[7:0], byte_index[15:8], frame_command[23:16], frame_len[31:24],
	// checksum_ok[32], command_match[33], status_error[34], zeros[39:35]
	output logic [xcfd_pkg::TDATA_W-1:0]      m_axis_tdata,
	output logic                              m_axis_tuser,  // item_kind
	input  wire logic                         cfg_valid,
	output logic                              cfg_ready,
	input  wire logic [7:0]                   cfg_data       // match_cmd
);

	logic             in_valid_s1;
	logic [7:0]       in_byte_s1;
	logic             out_valid_s2;
	logic             out_kind_s2;
	xcfd_pkg::result_t out_res_s2;

	xcfd_pkg::state_t state_q, state_d;
	logic [7:0]       cmd_q, cmd_d;
	logic [7:0]       len_q, len_d;
	logic [7:0]       seen_q, seen_d;
	logic [7:0]       xor_q, xor_d;
	logic             first_nz_q, first_nz_d;
	logic [7:0]       exp_cmd_q;

	logic             out_free;
	logic             advance;
	logic             res_valid;
	logic             res_kind;
	xcfd_pkg::result_t res;
	logic [7:0]       seen_inc;

	assign out_free      = !out_valid_s2 || m_axis_tready;
	assign advance       = in_valid_s1 && out_free;
	assign s_axis_tready = !in_valid_s1 || out_free;
	assign cfg_ready     = 1'b1;
	assign seen_inc      = seen_q + 8'd1;

	always_comb begin
		state_d    = state_q;
		cmd_d      = cmd_q;
		len_d      = len_q;
		seen_d     = seen_q;
		xor_d      = xor_q;
		first_nz_d = first_nz_q;
		res_valid  = 1'b0;
		res_kind   = xcfd_pkg::KIND_PAYLOAD;
		res        = '0;
		unique case (state_q)
			xcfd_pkg::ST_HUNT: begin
				if (in_byte_s1 == xcfd_pkg::START_BYTE) begin
					cmd_d      = '0;
					len_d      = '0;
					seen_d     = '0;
					first_nz_d = 1'b0;
					xor_d      = xcfd_pkg::XOR_INIT ^ in_byte_s1;
					state_d    = xcfd_pkg::ST_CMD;
				end
			end
			xcfd_pkg::ST_CMD: begin
				cmd_d   = in_byte_s1;
				xor_d   = xor_q ^ in_byte_s1;
				state_d = xcfd_pkg::ST_LEN;
			end
			xcfd_pkg::ST_LEN: begin
				len_d   = in_byte_s1;
				xor_d   = xor_q ^ in_byte_s1;
				seen_d  = '0;
				state_d = (in_byte_s1 == 8'd0) ? xcfd_pkg::ST_CHECK : xcfd_pkg::ST_DATA;
			end
			xcfd_pkg::ST_DATA: begin
				res_valid         = 1'b1;
				res.data_byte     = in_byte_s1;
				res.byte_index    = seen_q;
				res.frame_command = cmd_q;
				res.frame_len     = len_q;
				if (seen_q == 8'd0 && in_byte_s1 != 8'd0) begin
					first_nz_d = 1'b1;
				end
				xor_d  = xor_q ^ in_byte_s1;
				seen_d = seen_inc;
				if (seen_inc == len_q) begin
					state_d = xcfd_pkg::ST_CHECK;
				end
			end
			xcfd_pkg::ST_CHECK: begin
				res_valid         = 1'b1;
				res_kind          = xcfd_pkg::KIND_SUMMARY;
				res.frame_command = cmd_q;
				res.frame_len     = len_q;
				res.checksum_ok   = (xor_q == in_byte_s1);
				res.command_match = (cmd_q == exp_cmd_q);
				res.status_error  = (len_q != 8'd0) && first_nz_q;
				state_d           = xcfd_pkg::ST_HUNT;
			end
			default: begin
				state_d = xcfd_pkg::ST_HUNT;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			in_valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			in_byte_s1 <= s_axis_tdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= xcfd_pkg::ST_HUNT;
			cmd_q      <= '0;
			len_q      <= '0;
			seen_q     <= '0;
			xor_q      <= xcfd_pkg::XOR_INIT;
			first_nz_q <= 1'b0;
		end else if (advance) begin
			state_q    <= state_d;
			cmd_q      <= cmd_d;
			len_q      <= len_d;
			seen_q     <= seen_d;
			xor_q      <= xor_d;
			first_nz_q <= first_nz_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_cmd_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			exp_cmd_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (advance) begin
			out_valid_s2 <= res_valid;
		end else if (m_axis_tready) begin
			out_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_valid) begin
			out_kind_s2 <= res_kind;
			out_res_s2  <= res;
		end
	end

	assign m_axis_tvalid = out_valid_s2;
	assign m_axis_tuser  = out_kind_s2;
	assign m_axis_tdata  = {{(xcfd_pkg::TDATA_W - $bits(xcfd_pkg::result_t)){1'b0}}, out_res_s2};

endmodule

`default_nettype wire

/* rtl/xcfd_checker.sv */
// Port-level checker for the XOR-checked frame deframer, bound to the top level.
// Depends on xor_checked_frame_deframer_assert.svh.
`default_nettype none

`include "xor_checked_frame_deframer_assert.svh"

module xcfd_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        m_axis_tvalid,
	input wire logic        m_axis_tready,
	input wire logic [39:0] m_axis_tdata,
	input wire logic        m_axis_tuser
);

	`XCFD_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled output transfer changed")
	`XCFD_ASSERT(a_summary_zero, m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[15:0] == 16'd0, "summary carries payload byte fields")
	`XCFD_ASSERT(a_payload_flags, m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[39:32] == 8'd0, "payload item carries summary flags")
	`XCFD_ASSERT(a_index_range, m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[15:8] < m_axis_tdata[31:24], "payload index beyond declared length")
	`XCFD_ASSERT_ALWAYS(a_reset_quiet, !arst_n |-> !m_axis_tvalid, "output valid during reset")

endmodule

bind xor_checked_frame_deframer xcfd_checker u_xcfd_checker (.*);

`default_nettype wire

/* sim/tb.sv */
// Self-checking testbench for xor_checked_frame_deframer: drives received bytes
// with random gaps and checks every output transfer against a built-in frame parser.
// Depends on xcfd_pkg and the xor_checked_frame_deframer RTL.
`default_nettype none

module tb;

	localparam int STUCK_LIMIT = 1000;

	typedef struct {
		logic              kind;
		xcfd_pkg::result_t fields;
	} deframe_item_t;

	class deframe_tracker_t;
		deframe_item_t    pending_items[$];
		xcfd_pkg::state_t parse_state;
		logic [7:0]       match_cmd;
		logic [7:0]       cur_cmd;
		logic [7:0]       cur_len;
		logic [7:0]       payload_seen;
		logic [7:0]       xor_acc;
		logic             first_nonzero;
		int               errors;

		function new();
			match_cmd = 8'h00;
			parse_state = xcfd_pkg::ST_HUNT;
			clear_frame();
			errors = 0;
		endfunction

		function void clear_frame();
			cur_cmd = 8'h00;
			cur_len = 8'h00;
			payload_seen = 8'h00;
			xor_acc = xcfd_pkg::XOR_INIT;
			first_nonzero = 1'b0;
		endfunction

		function void set_match_cmd(logic [7:0] value);
			match_cmd = value;
		endfunction

		function bit hunting();
			return parse_state == xcfd_pkg::ST_HUNT;
		endfunction

		function int outstanding();
			return pending_items.size();
		endfunction

		task report(string msg);
			if (errors < 40)
				$display("%0t: %s", $time, msg);
			errors++;
		endtask

		task take_rx_byte(logic [7:0] b);
			deframe_item_t e;
			e.kind = xcfd_pkg::KIND_PAYLOAD;
			e.fields = '0;
			case (parse_state)
				xcfd_pkg::ST_HUNT: begin
					if (b == xcfd_pkg::START_BYTE) begin
						clear_frame();
						xor_acc = xcfd_pkg::XOR_INIT ^ b;
						parse_state = xcfd_pkg::ST_CMD;
					end
				end
				xcfd_pkg::ST_CMD: begin
					cur_cmd = b;
					xor_acc ^= b;
					parse_state = xcfd_pkg::ST_LEN;
				end
				xcfd_pkg::ST_LEN: begin
					cur_len = b;
					xor_acc ^= b;
					payload_seen = 8'h00;
					parse_state = (b == 8'h00) ? xcfd_pkg::ST_CHECK : xcfd_pkg::ST_DATA;
				end
				xcfd_pkg::ST_DATA: begin
					e.fields.data_byte = b;
					e.fields.byte_index = payload_seen;
					e.fields.frame_command = cur_cmd;
					e.fields.frame_len = cur_len;
					if (payload_seen == 8'h00 && b != 8'h00)
						first_nonzero = 1'b1;
					xor_acc ^= b;
					payload_seen = payload_seen + 8'd1;
					if (payload_seen == cur_len)
						parse_state = xcfd_pkg::ST_CHECK;
					pending_items.push_back(e);
				end
				xcfd_pkg::ST_CHECK: begin
					e.kind = xcfd_pkg::KIND_SUMMARY;
					e.fields.frame_command = cur_cmd;
					e.fields.frame_len = cur_len;
					e.fields.checksum_ok = (xor_acc == b);
					e.fields.command_match = (cur_cmd == match_cmd);
					e.fields.status_error = (cur_len != 8'h00) && first_nonzero;
					parse_state = xcfd_pkg::ST_HUNT;
					pending_items.push_back(e);
				end
				default: parse_state = xcfd_pkg::ST_HUNT;
			endcase
		endtask

		task check_field(string name, logic [7:0] got, logic [7:0] want);
			if (got !== want)
				report($sformatf("%s mismatch: got 0x%02h, expected 0x%02h", name, got, want));
		endtask

		task check_output(logic kind, logic [xcfd_pkg::TDATA_W-1:0] bus);
			deframe_item_t     e;
			xcfd_pkg::result_t got;
			if (pending_items.size() == 0) begin
				report($sformatf("unexpected output transfer: tuser %0b tdata 0x%010h", kind, bus));
			end else begin
				e = pending_items.pop_front();
				got = xcfd_pkg::result_t'(bus[$bits(xcfd_pkg::result_t)-1:0]);
				check_field("item_kind", 8'(kind), 8'(e.kind));
				check_field("data_byte", got.data_byte, e.fields.data_byte);
				check_field("byte_index", got.byte_index, e.fields.byte_index);
				check_field("frame_command", got.frame_command, e.fields.frame_command);
				check_field("frame_len", got.frame_len, e.fields.frame_len);
				check_field("checksum_ok", 8'(got.checksum_ok), 8'(e.fields.checksum_ok));
				check_field("command_match", 8'(got.command_match), 8'(e.fields.command_match));
				check_field("status_error", 8'(got.status_error), 8'(e.fields.status_error));
				check_field("tdata padding",
					8'(bus[xcfd_pkg::TDATA_W-1:$bits(xcfd_pkg::result_t)]), 8'h00);
			end
		endtask
	endclass

	logic                          clk;
	logic                          arst_n;
	logic                          s_axis_tvalid;
	logic                          s_axis_tready;
	logic [7:0]                    s_axis_tdata;
	logic                          m_axis_tvalid;
	logic                          m_axis_tready = 1'b0;
	logic [xcfd_pkg::TDATA_W-1:0]  m_axis_tdata;
	logic                          m_axis_tuser;
	logic                          cfg_valid;
	logic                          cfg_ready;
	logic [7:0]                    cfg_data;

	deframe_tracker_t tracker = new();
	logic [7:0]       frame_buf[$];
	bit               no_stalls;
	int               stall_left = 0;
	int               stuck_cycles = 0;

	xor_checked_frame_deframer dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	function automatic int pick_gap();
		int r;
		if (no_stalls)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	always @(negedge clk) begin
		if (stall_left == 0)
			stall_left = pick_gap();
		if (stall_left > 0) begin
			m_axis_tready <= 1'b0;
			stall_left--;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				tracker.set_match_cmd(cfg_data);
			if (s_axis_tvalid && s_axis_tready)
				tracker.take_rx_byte(s_axis_tdata);
			if (m_axis_tvalid && m_axis_tready)
				tracker.check_output(m_axis_tuser, m_axis_tdata);
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
				|| (cfg_valid && cfg_ready)) begin
			stuck_cycles <= 0;
		end else if (stuck_cycles == STUCK_LIMIT) begin
			$display("xor_checked_frame_deframer regression: fail");
			$finish;
		end else begin
			stuck_cycles <= stuck_cycles + 1;
		end
	end

	task automatic send_byte(input logic [7:0] b);
		int gap;
		gap = pick_gap();
		@(negedge clk);
		repeat (gap) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	task automatic idle_rx();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
	endtask

	task automatic send_frame(input logic [7:0] cmd, input bit bad_sum);
		logic [7:0] sum;
		sum = xcfd_pkg::START_BYTE ^ cmd ^ 8'(frame_buf.size());
		send_byte(xcfd_pkg::START_BYTE);
		send_byte(cmd);
		send_byte(8'(frame_buf.size()));
		foreach (frame_buf[k]) begin
			sum ^= frame_buf[k];
			send_byte(frame_buf[k]);
		end
		if (bad_sum)
			sum ^= 8'($urandom_range(1, 255));
		send_byte(sum);
	endtask

	task automatic fill_payload(input int len, input bit first_zero);
		frame_buf.delete();
		repeat (len) frame_buf.push_back(8'($urandom_range(0, 255)));
		if (first_zero && len > 0)
			frame_buf[0] = 8'h00;
	endtask

	// The parser may still be working on a byte that yields no result, so the task
	// waits after the last result before the register is touched.
	task automatic write_match_cmd(input logic [7:0] value);
		idle_rx();
		while (tracker.outstanding() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		int         sent;
		int         len;
		logic [7:0] cmd;
		arst_n = 1'b1;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = 8'h00;
		cfg_valid = 1'b0;
		cfg_data = 8'h00;
		no_stalls = 1'b0;
		#1 arst_n = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed frames run with the register at its reset value first.
		send_byte(8'h00);
		send_byte(8'h7E);
		frame_buf.delete();
		send_frame(8'h00, 1'b0);
		frame_buf = '{8'h00, 8'hFF};
		send_frame(8'hFF, 1'b1);
		frame_buf = '{8'h80};
		send_frame(8'h5A, 1'b0);
		write_match_cmd(8'hFF);
		frame_buf = '{8'h01};
		send_frame(8'hFF, 1'b0);

		for (int ph = 0; ph < 6; ph++) begin
			if (ph == 0)
				write_match_cmd(8'h00);
			else if (ph == 1)
				write_match_cmd(8'hFF);
			else
				write_match_cmd(8'($urandom_range(0, 255)));
			no_stalls = (ph == 2);
			if (ph == 3) begin
				fill_payload(255, 1'b0);
				send_frame(8'($urandom_range(0, 255)), 1'b0);
			end
			sent = 0;
			while (sent < 20) begin
				if ($urandom_range(0, 99) < 85) begin
					repeat ($urandom_range(0, 2)) send_byte(8'($urandom_range(0, 254)));
					cmd = ($urandom_range(0, 99) < 30) ? tracker.match_cmd
						: 8'($urandom_range(0, 255));
					len = ($urandom_range(0, 99) < 70) ? $urandom_range(0, 4)
						: $urandom_range(5, 16);
					fill_payload(len, $urandom_range(0, 99) < 30);
					send_frame(cmd, $urandom_range(0, 99) < 25);
					sent += len + 4;
				end else begin
					len = $urandom_range(1, 8);
					repeat (len) begin
						if ($urandom_range(0, 99) < 30)
							send_byte(xcfd_pkg::START_BYTE);
						else
							send_byte(8'($urandom_range(0, 255)));
					end
					sent += len;
				end
			end
			idle_rx();
			while (!tracker.hunting()) begin
				send_byte(8'($urandom_range(0, 254)));
				idle_rx();
			end
		end
		no_stalls = 1'b0;

		idle_rx();
		while (tracker.outstanding() != 0) @(posedge clk);
		repeat (6) @(posedge clk);
		if (tracker.errors == 0)
			$display("xor_checked_frame_deframer regression: pass");
		else
			$display("xor_checked_frame_deframer regression: fail");
		$finish;
	end
endmodule

`default_nettype wire
